FILE: design/gbf_pkg.sv
package gbf_pkg;

   // channel field widths
   localparam int unsigned COORD_W   = 10;
   localparam int unsigned OFFSET_W  = 12;
   localparam int unsigned AMP_W     = 8;
   localparam int unsigned SUM_W     = 20;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DAT_W = 12;

   // datapath widths
   localparam int unsigned DSQ_W      = 2 * COORD_W;      // dx*dx
   localparam int unsigned D2_W       = DSQ_W + 1;        // dx*dx + dy*dy
   localparam int unsigned INV_W      = 18;               // round(2^26 / s^2)
   localparam int unsigned PROD_W     = D2_W + INV_W;     // d2 * inv
   localparam int unsigned T_W        = 14;               // t below 16.0 in Q4.10
   localparam int unsigned EXP_W      = 16;               // exp(-t) in Q0.16
   localparam int unsigned EXP_ADDR_W = 12;               // deepest supported exp table
   localparam int unsigned IDX_MUL_W  = T_W + EXP_ADDR_W + 1;
   localparam int unsigned AMP_PROD_W = AMP_W + EXP_W;
   localparam int unsigned TERM_W     = 17;
   localparam int unsigned GRP_LANES  = 4;
   localparam int unsigned GRP_W      = TERM_W + 2;
   localparam int unsigned TOTAL_W    = SUM_W + 1;

   localparam logic [SUM_W-1:0]    SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [TERM_W-1:0]   TERM_MAX = TERM_W'(65280);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(50);
   localparam logic [AMP_W-1:0]    AMP_RESET    = AMP_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIELD_OFFSET   = 4'd0,
      CSR_BLOB_AMPLITUDE = 4'd1
   } csr_index_type;

   // blob table: centre and rounded inverse squared radius
   localparam int unsigned BLOB_TAB_LEN = 13;

   localparam logic [COORD_W-1:0] BLOB_CX [BLOB_TAB_LEN] = '{
      10'd300, 10'd300, 10'd300, 10'd355, 10'd355, 10'd233, 10'd180,
      10'd220, 10'd180, 10'd140, 10'd380, 10'd420, 10'd460
   };
   localparam logic [COORD_W-1:0] BLOB_CY [BLOB_TAB_LEN] = '{
      10'd220, 10'd340, 10'd450, 10'd120, 10'd70,  10'd130, 10'd140,
      10'd330, 10'd350, 10'd360, 10'd330, 10'd350, 10'd360
   };
   // radii 95 60 40 30 25 30 25 20 20 18 20 20 18
   localparam logic [INV_W-1:0] BLOB_INV [BLOB_TAB_LEN] = '{
      18'd7436,   18'd18641,  18'd41943,  18'd74565,  18'd107374,
      18'd74565,  18'd107374, 18'd167772, 18'd167772, 18'd207126,
      18'd167772, 18'd167772, 18'd207126
   };

   // exp table generation, Q30 arithmetic
   localparam longint unsigned Q30_ONE  = 64'd1 << 30;
   localparam longint unsigned Q30_HALF = 64'd1 << 29;

   function automatic longint unsigned q30_mul(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b + Q30_HALF) >> 30;
   endfunction

   // table write port shared by all blob lanes during the fill sweep
   typedef struct packed {
      logic                  we;
      logic [EXP_ADDR_W-1:0] addr;
      logic [EXP_W-1:0]      data;
   } fill_type;

endpackage

FILE: design/gbf_if.sv
interface gbf_req_if import gbf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gbf_rsp_if import gbf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic [SUM_W-1:0]   field_sum;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;

   modport source (output valid, output inside_res, output field_sum,
                   output out_x, output out_y, input ready);
   modport sink   (input valid, input inside_res, input field_sum,
                   input out_x, input out_y, output ready);
endinterface

interface gbf_csr_if import gbf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/gaussian_blob_field_inside_test.sv
// Metaball inside test: one pixel per transaction, a fixed set of gaussian blobs.
//
// req_bus  : pixel_x / pixel_y, valid/ready. rsp_bus: inside_res, field_sum (Q12.8,
//            saturating), out_x / out_y echo, valid/ready. csr_bus: register index
//            and data, always ready; index 0 field_offset, 1 blob_amplitude, others
//            ignored. Write registers only while no transaction is in flight.
// Throughput: one pixel per clock while rsp_bus takes results. All blob lanes run in
//            parallel, each lane holds a private copy of the exp table in its own RAM,
//            so every lane does one table read per cycle while the pipeline advances.
// Stages  : req transaction to rsp valid runs through input reg, |d|, d^2, sum,
//            scale, table index, RAM read, amplitude, partial sums, output.
// Reset   : registers return to 50 / 100. The exp tables are then filled one
//            entry per cycle; req ready stays low until that is done. csr writes
//            are taken meanwhile.
// Stall   : the whole pipeline advances only while the output register is empty
//            or being taken, so a stalled rsp_bus holds every stage in place and
//            req ready drops in the same cycle. Nothing is lost or repeated.
module gaussian_blob_field_inside_test_top import gbf_pkg::*; #(
   parameter int unsigned NUM_BLOBS       = 13,
   parameter int unsigned COORD_BITS      = 10,
   parameter int unsigned EXP_TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   gbf_req_if.sink      req_bus,
   gbf_rsp_if.source    rsp_bus,
   gbf_csr_if.sink      csr_bus
);

   // blob count is clipped to the table; coordinates masked to COORD_BITS
   localparam int unsigned NumLanes = (NUM_BLOBS < BLOB_TAB_LEN) ? NUM_BLOBS : BLOB_TAB_LEN;
   localparam int unsigned NumGrps  = (NumLanes + GRP_LANES - 1) / GRP_LANES;
   localparam int unsigned CoordW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   // stages A (input) .. I (partial sums); output register follows
   localparam int unsigned PipeN    = 9;
   localparam int unsigned TermStg  = 7;
   localparam logic [TOTAL_W-1:0] SumBound = TOTAL_W'(NumLanes * 65280);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } echo_type;

   // ---------------- configuration registers ----------------
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [AMP_W-1:0]    amp_ff, amp_in;

   always_comb begin
      offset_in = offset_ff;
      amp_in    = amp_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_FIELD_OFFSET:   offset_in = csr_bus.data[OFFSET_W-1:0];
            CSR_BLOB_AMPLITUDE: amp_in    = csr_bus.data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         amp_ff    <= AMP_RESET;
      end else begin
         offset_ff <= offset_in;
         amp_ff    <= amp_in;
      end
   end

   assign csr_bus.ready = 1'b1;

   // ---------------- exp table fill after reset ----------------
   fill_type fill;
   logic     fill_busy;

   gbf_fill #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_fill (
      .clock (clock),
      .reset (reset),
      .fill  (fill),
      .busy  (fill_busy)
   );

   // ---------------- pipeline control ----------------
   logic adv;          // every stage moves when the output slot frees up
   logic req_take;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PipeN-1:0]    v_ff, v_in;
   echo_type            echo_ff [PipeN];
   logic [CoordW-1:0]   px_ff, py_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv && !fill_busy;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      v_in = {v_ff[PipeN-2:0], req_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         echo_ff[0] <= '{x: req_bus.pixel_x, y: req_bus.pixel_y};
         for (int i = 1; i < PipeN; i++) begin
            echo_ff[i] <= echo_ff[i-1];
         end
         px_ff <= req_bus.pixel_x[CoordW-1:0];
         py_ff <= req_bus.pixel_y[CoordW-1:0];
      end
   end

   // ---------------- blob lanes ----------------
   logic [TERM_W-1:0] term [NumLanes];

   for (genvar b = 0; b < NumLanes; b++) begin : g_lane
      gbf_lane #(
         .BLOB_IDX        (b),
         .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_lane (
         .clock (clock),
         .adv   (adv),
         .px    (COORD_W'(px_ff)),
         .py    (COORD_W'(py_ff)),
         .amp   (amp_ff),
         .fill  (fill),
         .term  (term[b])
      );
   end

   // ---------------- summation ----------------
   // partial sums over groups of four lanes, then the final add and compare
   logic [GRP_W-1:0]   grp_ff [NumGrps];
   logic [GRP_W-1:0]   grp_in [NumGrps];
   logic [TOTAL_W-1:0] total;
   logic [SUM_W-1:0]   sum_sat;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               inside_ff, inside_in;
   echo_type           out_echo_ff;

   always_comb begin
      for (int g = 0; g < NumGrps; g++) begin
         grp_in[g] = '0;
      end
      for (int i = 0; i < NumLanes; i++) begin
         grp_in[i / GRP_LANES] = grp_in[i / GRP_LANES] + GRP_W'(term[i]);
      end
      total = '0;
      for (int g = 0; g < NumGrps; g++) begin
         total = total + TOTAL_W'(grp_ff[g]);
      end
      sum_sat      = (total > TOTAL_W'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
      sum_in       = sum_sat;
      inside_in    = {offset_ff, 8'h00} <= sum_sat;
      rsp_valid_in = v_ff[PipeN-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         grp_ff      <= grp_in;
         sum_ff      <= sum_in;
         inside_ff   <= inside_in;
         out_echo_ff <= echo_ff[PipeN-1];
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.inside_res = inside_ff;
   assign rsp_bus.field_sum  = sum_ff;
   assign rsp_bus.out_x      = out_echo_ff.x;
   assign rsp_bus.out_y      = out_echo_ff.y;

`ifndef SYNTHESIS
   // no pixel may enter before the exp tables are complete
   a_no_req_during_fill: assert property (@(posedge clock) disable iff (reset)
      fill_busy |-> (v_ff == '0) && !rsp_valid_ff && !req_take)
      else $error("pixel in flight while exp tables are being filled");

   // table writes only happen inside the fill window
   a_fill_write_window: assert property (@(posedge clock) disable iff (reset)
      fill.we |-> fill_busy)
      else $error("exp table write outside fill window");

   // bounded by lanes times the largest term, so saturation never hides an error
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (TOTAL_W'(sum_ff) <= SumBound))
      else $error("field sum above the blob bound");

   // a new result appears only from an item that reached the last stage
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v_ff[PipeN-1]) && $past(adv))
      else $error("result produced without a pipeline item");

   // a valid term stage reaches the partial-sum stage whenever the pipeline advances
   a_term_stage_valid: assert property (@(posedge clock) disable iff (reset)
      (v_ff[TermStg] && adv) |=> v_ff[TermStg+1])
      else $error("valid lost between term and partial-sum stages");
`endif

endmodule

FILE: design/gbf_ram.sv
module gbf_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gbf_fill.sv
module gbf_fill import gbf_pkg::*; #(
   parameter int unsigned EXP_TABLE_DEPTH = 1024,
   localparam int unsigned AddrW = $clog2(EXP_TABLE_DEPTH)
) (
   input  logic     clock,
   input  logic     reset,
   output fill_type fill,
   output logic     busy
);

   typedef logic [EXP_TABLE_DEPTH*EXP_W-1:0] rom_bits_type;

   // exp(-k*16/depth): exp(-t/256) by a 5th order series, then squared 8 times
   function automatic rom_bits_type build_rom();
      rom_bits_type      bits;
      longint unsigned   u, x, x2, x3, x4, x5, pos, neg, e, r;
      bits = '0;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         u   = 64'(k);
         u   = (u << 34) / EXP_TABLE_DEPTH;
         x   = u >> 8;
         x2  = q30_mul(x, x);
         x3  = q30_mul(x2, x);
         x4  = q30_mul(x3, x);
         x5  = q30_mul(x4, x);
         pos = Q30_ONE + x2 / 2 + x4 / 24;
         neg = x + x3 / 6 + x5 / 120;
         e   = (pos > neg) ? pos - neg : 64'd0;
         if (e > Q30_ONE) e = Q30_ONE;
         for (int i = 0; i < 8; i++) e = q30_mul(e, e);
         r = (e + (64'd1 << 13)) >> 14;
         if (r > 64'd65535) r = 64'd65535;
         bits[k*EXP_W +: EXP_W] = r[EXP_W-1:0];
      end
      return bits;
   endfunction

   localparam rom_bits_type ExpRomBits = build_rom();
   localparam logic [AddrW-1:0] LastAddr = AddrW'(EXP_TABLE_DEPTH - 1);

   logic                  issue_ff, issue_in;
   logic [AddrW-1:0]      cnt_ff, cnt_in;
   logic                  we_ff, we_in;
   logic [EXP_ADDR_W-1:0] addr_ff, addr_in;
   logic [EXP_W-1:0]      data_ff, data_in;

   always_comb begin
      issue_in = issue_ff;
      cnt_in   = cnt_ff;
      we_in    = issue_ff;
      addr_in  = EXP_ADDR_W'(cnt_ff);
      data_in  = ExpRomBits[{cnt_ff, 4'b0000} +: EXP_W];
      if (issue_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastAddr) begin
            issue_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b1;
         cnt_ff   <= '0;
         we_ff    <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         cnt_ff   <= cnt_in;
         we_ff    <= we_in;
      end
      addr_ff <= addr_in;
      data_ff <= data_in;
   end

   assign fill.we   = we_ff;
   assign fill.addr = addr_ff;
   assign fill.data = data_ff;
   assign busy      = issue_ff | we_ff;

endmodule

FILE: design/gbf_lane.sv
module gbf_lane import gbf_pkg::*; #(
   parameter int unsigned BLOB_IDX        = 0,
   parameter int unsigned EXP_TABLE_DEPTH = 1024,
   localparam int unsigned AddrW = $clog2(EXP_TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               adv,
   input  logic [COORD_W-1:0] px,
   input  logic [COORD_W-1:0] py,
   input  logic [AMP_W-1:0]   amp,
   input  fill_type           fill,
   output logic [TERM_W-1:0]  term
);

   localparam logic [COORD_W-1:0] Cx  = BLOB_CX[BLOB_IDX];
   localparam logic [COORD_W-1:0] Cy  = BLOB_CY[BLOB_IDX];
   localparam logic [INV_W-1:0]   Inv = BLOB_INV[BLOB_IDX];

   logic [COORD_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [DSQ_W-1:0]     dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [D2_W-1:0]      d2_ff, d2_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [IDX_MUL_W-1:0] idx_mul;
   logic [AddrW-1:0]     idx_ff, idx_in;
   logic                 far_ff, far_in, far_g_ff;
   logic [EXP_W-1:0]     entry;
   logic [AMP_PROD_W-1:0] scaled;
   logic [TERM_W-1:0]    term_ff, term_in;

   always_comb begin
      dx_in   = (px >= Cx) ? px - Cx : Cx - px;
      dy_in   = (py >= Cy) ? py - Cy : Cy - py;
      dx2_in  = DSQ_W'(dx_ff) * DSQ_W'(dx_ff);
      dy2_in  = DSQ_W'(dy_ff) * DSQ_W'(dy_ff);
      d2_in   = D2_W'(dx2_ff) + D2_W'(dy2_ff);
      prod_in = PROD_W'(d2_ff) * PROD_W'(Inv);
      // t = prod >> 16; t of 16.0 or more gives no contribution
      far_in  = |prod_ff[PROD_W-1:T_W+16];
      idx_mul = IDX_MUL_W'(prod_ff[T_W+15:16]) * IDX_MUL_W'(EXP_TABLE_DEPTH);
      idx_in  = idx_mul[T_W +: AddrW];
      scaled  = AMP_PROD_W'(amp) * AMP_PROD_W'(entry) + AMP_PROD_W'(128);
      term_in = far_g_ff ? '0 : TERM_W'(scaled[AMP_PROD_W-1:8]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         d2_ff    <= d2_in;
         prod_ff  <= prod_in;
         idx_ff   <= idx_in;
         far_ff   <= far_in;
         far_g_ff <= far_ff;
         term_ff  <= term_in;
      end
   end

   gbf_ram #(
      .WIDTH (EXP_W),
      .DEPTH (EXP_TABLE_DEPTH)
   ) u_exp_ram (
      .clock   (clock),
      .we      (fill.we),
      .wr_addr (fill.addr[AddrW-1:0]),
      .wr_data (fill.data),
      .rd_en   (adv),
      .rd_addr (idx_ff),
      .rd_data (entry)
   );

   assign term = term_ff;

endmodule

FILE: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gbf_pkg::*;

   // ------------------------------------------------------------------
   // Testbench constants
   // ------------------------------------------------------------------
   localparam int unsigned BALL_COUNT   = 13;
   localparam int unsigned EXP_DEPTH    = 1024;
   localparam int unsigned T_LIMIT      = 16384;   // t = 16.0 in Q6.10
   localparam int unsigned PIPE_LATENCY = 9;
   localparam int unsigned MAX_WAIT     = 10;
   localparam int unsigned RANDOM_PHASE = 200;

   // register indexes the block does not decode; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = CSR_IDX_W'(15);

   // blob centres and radii
   localparam int unsigned BALL_X [BALL_COUNT] = '{
      300, 300, 300, 355, 355, 233, 180, 220, 180, 140, 380, 420, 460};
   localparam int unsigned BALL_Y [BALL_COUNT] = '{
      220, 340, 450, 120,  70, 130, 140, 330, 350, 360, 330, 350, 360};
   localparam int unsigned BALL_R [BALL_COUNT] = '{
       95,  60,  40,  30,  25,  30,  25,  20,  20,  18,  20,  20,  18};

   // directed pixels: corners, alternating bit patterns, every blob centre,
   // and both sides of the large-distance cutoff of the widest blob (4 radii)
   localparam int unsigned DIRECTED_LEN = 22;
   localparam int unsigned DIR_X [DIRECTED_LEN] = '{
      0, 1023, 0, 1023, 682, 341,
      300, 300, 300, 355, 355, 233, 180, 220, 180, 140, 380, 420, 460,
      680, 679, 300};
   localparam int unsigned DIR_Y [DIRECTED_LEN] = '{
      0, 1023, 1023, 0, 341, 682,
      220, 340, 450, 120, 70, 130, 140, 330, 350, 360, 330, 350, 360,
      220, 220, 300};

   typedef struct packed {
      logic               hit;
      logic [SUM_W-1:0]   sum;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pixel_result_type;

   // ------------------------------------------------------------------
   // Field predictor and result store
   // ------------------------------------------------------------------
   class blob_field_scoreboard;
      pixel_result_type awaited_q[$];
      logic [EXP_W-1:0] exp_rom [EXP_DEPTH];
      int               mismatches;
      int               results_checked;
      int               inside_seen;

      function new();
         mismatches      = 0;
         results_checked = 0;
         inside_seen     = 0;
         for (int k = 0; k < EXP_DEPTH; k++) begin
            exp_rom[k] = exp_entry(k);
         end
      endfunction

      function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
         return (a * b + (64'd1 << 29)) >> 30;
      endfunction

      // exp(-k*16/DEPTH): 5th order series of exp(-v/256), then squared 8 times
      function logic [EXP_W-1:0] exp_entry(int unsigned k);
         longint unsigned v, p2, p3, p4, p5, plus, minus, e, r;
         v     = ((longint'(k) << 34) / EXP_DEPTH) >> 8;
         p2    = mul_q30(v, v);
         p3    = mul_q30(p2, v);
         p4    = mul_q30(p3, v);
         p5    = mul_q30(p4, v);
         plus  = (64'd1 << 30) + p2 / 2 + p4 / 24;
         minus = v + p3 / 6 + p5 / 120;
         e     = (plus > minus) ? plus - minus : 0;
         if (e > (64'd1 << 30)) e = 64'd1 << 30;
         for (int i = 0; i < 8; i++) e = mul_q30(e, e);
         r = (e + (64'd1 << 13)) >> 14;
         return (r > 65535) ? EXP_W'(65535) : EXP_W'(r);
      endfunction

      function logic [SUM_W-1:0] field_at(int unsigned px, int unsigned py,
                                          logic [AMP_W-1:0] amp);
         longint unsigned dx, dy, d2, s2, inv, t, term, acc;
         acc = 0;
         for (int b = 0; b < BALL_COUNT; b++) begin
            dx  = (px >= BALL_X[b]) ? px - BALL_X[b] : BALL_X[b] - px;
            dy  = (py >= BALL_Y[b]) ? py - BALL_Y[b] : BALL_Y[b] - py;
            d2  = dx * dx + dy * dy;
            s2  = longint'(BALL_R[b]) * BALL_R[b];
            inv = ((64'd1 << 26) + s2 / 2) / s2;
            t   = (d2 * inv) >> 16;
            if (t > 65535) t = 65535;
            if (t >= T_LIMIT) term = 0;
            else term = (longint'(amp) * exp_rom[(t * EXP_DEPTH) >> 14] + 128) >> 8;
            acc += term;
            if (acc > SUM_MAX) acc = SUM_MAX;
         end
         return SUM_W'(acc);
      endfunction

      function void note_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                               logic [OFFSET_W-1:0] level, logic [AMP_W-1:0] amp);
         pixel_result_type r;
         r.sum = field_at(px, py, amp);
         r.hit = ((longint'(level) << 8) <= r.sum);
         r.x   = px;
         r.y   = py;
         awaited_q.push_back(r);
      endfunction

      function void check_result(logic hit, logic [SUM_W-1:0] sum,
                                 logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
         pixel_result_type r;
         if (awaited_q.size() == 0) begin
            $error("unexpected result: out_x %0d out_y %0d field_sum %0d", ox, oy, sum);
            mismatches++;
            return;
         end
         r = awaited_q.pop_front();
         results_checked++;
         if (hit === 1'b1) inside_seen++;
         if (hit !== r.hit) begin
            $error("inside_res: expected %0d, actual %0d", r.hit, hit);
            mismatches++;
         end
         if (sum !== r.sum) begin
            $error("field_sum: expected %0d, actual %0d", r.sum, sum);
            mismatches++;
         end
         if (ox !== r.x) begin
            $error("out_x: expected %0d, actual %0d", r.x, ox);
            mismatches++;
         end
         if (oy !== r.y) begin
            $error("out_y: expected %0d, actual %0d", r.y, oy);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return awaited_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, buses, block under test
   // ------------------------------------------------------------------
   logic clock;
   logic reset;

   gbf_req_if req_bus ();
   gbf_rsp_if rsp_bus ();
   gbf_csr_if csr_bus ();

   gaussian_blob_field_inside_test_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   blob_field_scoreboard field_board = new();

   // register copies as the block should hold them
   logic [OFFSET_W-1:0] level_setting     = OFFSET_RESET;
   logic [AMP_W-1:0]    amplitude_setting = AMP_RESET;

   int pixels_sent    = 0;
   int settings_tried = 1;
   int req_quiet      = 0;
   int rsp_quiet      = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run (table fill, ~1500
   // transactions each with full sender gap, receiver stall and latency).
   initial begin
      #4_000_000;
      $display("testbench: errors");
      $finish;
   end

   // Random per-transaction wait. Now and then a quiet stretch of 21..61
   // transactions runs back to back so the pipeline fills up.
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // ------------------------------------------------------------------
   // Result side: random backpressure, every accepted transaction checked
   // ------------------------------------------------------------------
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_wait(rsp_quiet);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         // ready was high before this edge, so valid here means a transaction
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         field_board.check_result(rsp_bus.inside_res, rsp_bus.field_sum,
                                  rsp_bus.out_x, rsp_bus.out_y);
      end
   end

   // ------------------------------------------------------------------
   // Driver tasks; each returns right after a rising edge
   // ------------------------------------------------------------------
   task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      field_board.note_pixel(px, py, level_setting, amplitude_setting);
      pixels_sent++;
   endtask

   // Stop sending and hold off until every result is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (field_board.outstanding() != 0);
   endtask

   // valid stays up between back-to-back writes; the last one drops it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] value, input bit last);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_FIELD_OFFSET:   level_setting     = value[OFFSET_W-1:0];
         CSR_BLOB_AMPLITUDE: amplitude_setting = value[AMP_W-1:0];
         default: ;  // undecoded index, nothing changes
      endcase
      if (last) csr_bus.valid <= 1'b0;
   endtask

   // New setting: a throwaway write to an undecoded index first, then both
   // registers. Amplitude data carries all 12 bits; only the low 8 count.
   task automatic apply_setting(input logic [CSR_DAT_W-1:0] level,
                                input logic [CSR_DAT_W-1:0] amp);
      write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                CSR_DAT_W'($urandom), 1'b0);
      write_csr(CSR_FIELD_OFFSET, level, 1'b0);
      write_csr(CSR_BLOB_AMPLITUDE, amp, 1'b1);
      settings_tried++;
   endtask

   // Mostly pixels in the blob cluster where the field is interesting,
   // the rest anywhere on the 10-bit grid so every coordinate bit toggles.
   // Optionally stalls once mid-phase until the pipeline is empty.
   task automatic random_pixels(input int count, input bit mid_pause);
      logic [COORD_W-1:0] px, py;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) != 0) begin
            px = COORD_W'($urandom_range(100, 540));
            py = COORD_W'($urandom_range(30, 500));
         end else begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
         end
         send_pixel(px, py);
         if (mid_pause && i == count / 2) drain();
      end
      drain();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.pixel_x <= '0;
      req_bus.pixel_y <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_FIELD_OFFSET;
      csr_bus.data    <= '0;
      reset           <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings (level 50, amplitude 100). The block fills its exp
      // tables first; req ready stays low and the driver just waits.
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         send_pixel(COORD_W'(DIR_X[i]), COORD_W'(DIR_Y[i]));
      end
      random_pixels(300, 1'b1);

      // Both registers at zero: every term vanishes, every pixel is inside.
      apply_setting('0, '0);
      random_pixels(150, 1'b0);

      // Both at full scale: the largest terms, no pixel can reach the level.
      apply_setting({CSR_DAT_W{1'b1}}, {CSR_DAT_W{1'b1}});
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         send_pixel(COORD_W'(DIR_X[i]), COORD_W'(DIR_Y[i]));
      end
      random_pixels(RANDOM_PHASE, 1'b0);

      // Random settings, levels low enough that inside and outside both occur.
      for (int s = 0; s < 4; s++) begin
         apply_setting(CSR_DAT_W'($urandom_range(0, 400)), CSR_DAT_W'($urandom));
         random_pixels(RANDOM_PHASE, s == 1);
      end

      // let any stray result show up before judging
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("summary: %0d pixels over %0d register settings, %0d results checked",
               pixels_sent, settings_tried, field_board.results_checked);
      $display("summary: %0d inside, %0d outside, %0d mismatches",
               field_board.inside_seen,
               field_board.results_checked - field_board.inside_seen,
               field_board.mismatches);
      if (field_board.mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
